### rtl/spmp_pkg.sv
// Shared types, constants and helper functions for the shortest path block.
// Used by every module under rtl; it depends on nothing else.
`timescale 1ns / 1ps

package spmp_pkg;

  // Sizing of the graph store and the node tables.
  localparam int MaxNodes   = 32;
  localparam int MetricBits = 16;

  // Fixed widths of the port fields.
  localparam int PortNodeBits    = 5;
  localparam int PortMaskBits    = 32;
  localparam int CountFieldBits  = 6;
  localparam int MetricFieldBits = 16;
  localparam int FieldNodes      = 32;

  // Derived sizes.
  localparam int NodeBits     = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int CountBits    = $clog2(MaxNodes + 1);
  localparam int NodeLim      = (MaxNodes < FieldNodes) ? MaxNodes : FieldNodes;
  localparam int EdgeAddrBits = 2 * NodeBits;
  localparam int EdgeDepth    = 2 ** EdgeAddrBits;
  localparam int EdgeBits     = MetricBits + 1;

  localparam int DistBits = 24;
  localparam logic [DistBits-1:0] DistInf = '1;

  localparam logic [63:0] MetricMax = (64'd1 << MetricBits) - 64'd1;

  localparam logic [CountFieldBits-1:0] CountReset = CountFieldBits'(32);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RUN   = 2'd2
  } cmd_e;

  typedef enum logic {
    CFG_ROOT  = 1'b0,
    CFG_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_MARK,
    ST_RELAX,
    ST_SETTLE,
    ST_EMIT
  } state_e;

  // Command from the top level to the search core.
  typedef struct packed {
    logic                      start;
    logic [1:0]                cmd;
    logic [NodeBits-1:0]       src;
    logic [NodeBits-1:0]       dst;
    logic                      ends_ok;
    logic [MetricBits-1:0]     metric;
    logic [PortNodeBits-1:0]   root;
    logic [CountBits-1:0]      count;
  } cmd_t;

  // One node result from the core, before output formatting.
  typedef struct packed {
    logic                  valid;
    logic [NodeBits-1:0]   node;
    logic [DistBits-1:0]   path_dist;
    logic [MaxNodes-1:0]   parents;
    logic                  last;
  } res_t;

  // Outputs of the shared add and compare unit.
  typedef struct packed {
    logic [DistBits-1:0] sum;
    logic                lt;
    logic                eq;
    logic                sat;
  } alu_res_t;

  // Clamp an incoming metric to the stored metric width.
  function automatic logic [MetricBits-1:0] sat_metric(input logic [MetricFieldBits-1:0] m);
    logic [63:0] wide;
    wide = 64'(m);
    if (wide > MetricMax) begin
      wide = MetricMax;
    end
    return wide[MetricBits-1:0];
  endfunction

endpackage

### rtl/spmp_alu.sv
// Shared add and compare unit of the shortest path search.
// Depends on spmp_pkg for widths and the result struct.
`timescale 1ns / 1ps

module spmp_alu (
  input  logic [spmp_pkg::DistBits-1:0]   base_i,
  input  logic [spmp_pkg::MetricBits-1:0] addend_i,
  input  logic [spmp_pkg::DistBits-1:0]   limit_i,
  output spmp_pkg::alu_res_t              res_o
);

  logic [spmp_pkg::DistBits:0] sum;
  logic [spmp_pkg::DistBits:0] limit_ext;

  assign sum       = {1'b0, base_i} + (spmp_pkg::DistBits + 1)'(addend_i);
  assign limit_ext = {1'b0, limit_i};

  always_comb begin
    res_o.sum = sum[spmp_pkg::DistBits-1:0];
    res_o.lt  = sum < limit_ext;
    res_o.eq  = sum == limit_ext;
    res_o.sat = sum >= {1'b0, spmp_pkg::DistInf};
  end

endmodule

### rtl/spmp_core.sv
// Sequencer, node tables and edge memory of the shortest path search.
// Depends on spmp_pkg and instantiates spmp_alu.
`timescale 1ns / 1ps

module spmp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spmp_pkg::cmd_t    cmd_i,
  output logic              busy_o,
  output spmp_pkg::res_t    res_o
);

  spmp_pkg::state_e state_q, state_d;

  logic [spmp_pkg::NodeBits-1:0]     idx_q, idx_d;
  logic [spmp_pkg::EdgeAddrBits-1:0] clr_addr_q, clr_addr_d;
  logic [spmp_pkg::CountBits-1:0]    n_q, n_d;
  logic                              found_q, found_d;
  logic                              rd_vld_q, rd_vld_d;

  logic [spmp_pkg::NodeBits-1:0]     pick_q, pick_d;
  logic [spmp_pkg::DistBits-1:0]     best_q, best_d;
  logic [spmp_pkg::NodeBits-1:0]     rd_idx_q, rd_idx_d;
  logic [spmp_pkg::EdgeBits-1:0]     rd_data_q;

  logic [spmp_pkg::DistBits-1:0]     dist_q [spmp_pkg::MaxNodes];
  logic [spmp_pkg::DistBits-1:0]     dist_d [spmp_pkg::MaxNodes];
  logic [spmp_pkg::MaxNodes-1:0]     done_q, done_d;
  logic [spmp_pkg::MaxNodes-1:0]     par_q [spmp_pkg::MaxNodes];
  logic [spmp_pkg::MaxNodes-1:0]     par_d [spmp_pkg::MaxNodes];

  logic [spmp_pkg::EdgeBits-1:0]     edge_mem [spmp_pkg::EdgeDepth];
  logic                              mem_we;
  logic [spmp_pkg::EdgeAddrBits-1:0] mem_waddr;
  logic [spmp_pkg::EdgeBits-1:0]     mem_wdata;
  logic                              mem_re;
  logic [spmp_pkg::EdgeAddrBits-1:0] mem_raddr;

  logic [spmp_pkg::DistBits-1:0]     alu_base;
  logic [spmp_pkg::MetricBits-1:0]   alu_addend;
  logic [spmp_pkg::DistBits-1:0]     alu_limit;
  spmp_pkg::alu_res_t                alu_res;

  logic                              accept;
  logic [spmp_pkg::NodeBits-1:0]     last_idx;
  logic                              root_ok;
  logic [spmp_pkg::NodeBits-1:0]     root_idx;
  logic [spmp_pkg::MaxNodes-1:0]     pick_bit;

  assign accept   = cmd_i.start && (state_q == spmp_pkg::ST_IDLE);
  assign last_idx = spmp_pkg::NodeBits'(n_q - spmp_pkg::CountBits'(1));
  assign root_ok  = 32'(cmd_i.root) < 32'(n_q);
  assign root_idx = spmp_pkg::NodeBits'(cmd_i.root);
  assign busy_o   = state_q != spmp_pkg::ST_IDLE;

  always_comb begin
    pick_bit         = '0;
    pick_bit[pick_q] = 1'b1;
  end

  // The unit either compares a table distance against the running minimum,
  // or adds an edge metric to the picked distance and compares with the head.
  always_comb begin
    if (rd_vld_q) begin
      alu_base   = best_q;
      alu_addend = rd_data_q[spmp_pkg::MetricBits-1:0];
      alu_limit  = dist_q[rd_idx_q];
    end else begin
      alu_base   = dist_q[idx_q];
      alu_addend = '0;
      alu_limit  = best_q;
    end
  end

  spmp_alu u_alu (
    .base_i   (alu_base),
    .addend_i (alu_addend),
    .limit_i  (alu_limit),
    .res_o    (alu_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      spmp_pkg::ST_CLEAR: begin
        if (clr_addr_q == '1) begin
          state_d = spmp_pkg::ST_IDLE;
        end
      end
      spmp_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_i.cmd)
            spmp_pkg::CMD_CLEAR: state_d = spmp_pkg::ST_CLEAR;
            spmp_pkg::CMD_RUN:   state_d = spmp_pkg::ST_INIT;
            default:             state_d = spmp_pkg::ST_IDLE;
          endcase
        end
      end
      spmp_pkg::ST_INIT: state_d = spmp_pkg::ST_SCAN;
      spmp_pkg::ST_SCAN: begin
        if (idx_q == last_idx) begin
          state_d = spmp_pkg::ST_MARK;
        end
      end
      spmp_pkg::ST_MARK: begin
        // Once the minimum is unreachable, nothing can relax any more.
        if (!found_q || best_q == spmp_pkg::DistInf) begin
          state_d = spmp_pkg::ST_EMIT;
        end else begin
          state_d = spmp_pkg::ST_RELAX;
        end
      end
      spmp_pkg::ST_RELAX: begin
        if (idx_q == last_idx) begin
          state_d = spmp_pkg::ST_SETTLE;
        end
      end
      spmp_pkg::ST_SETTLE: state_d = spmp_pkg::ST_SCAN;
      spmp_pkg::ST_EMIT: begin
        if (idx_q == last_idx) begin
          state_d = spmp_pkg::ST_IDLE;
        end
      end
      default: state_d = spmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d      = idx_q;
    clr_addr_d = clr_addr_q;
    n_d        = n_q;
    found_d    = found_q;
    rd_vld_d   = 1'b0;
    pick_d     = pick_q;
    best_d     = best_q;
    rd_idx_d   = idx_q;
    dist_d     = dist_q;
    done_d     = done_q;
    par_d      = par_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = {pick_q, idx_q};

    case (state_q)
      spmp_pkg::ST_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + spmp_pkg::EdgeAddrBits'(1);
      end
      spmp_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_i.cmd)
            spmp_pkg::CMD_CLEAR: clr_addr_d = '0;
            spmp_pkg::CMD_ADD: begin
              mem_we    = cmd_i.ends_ok;
              mem_waddr = {cmd_i.src, cmd_i.dst};
              mem_wdata = {1'b1, cmd_i.metric};
            end
            spmp_pkg::CMD_RUN: n_d = cmd_i.count;
            default: ;
          endcase
        end
      end
      spmp_pkg::ST_INIT: begin
        for (int i = 0; i < spmp_pkg::MaxNodes; i++) begin
          dist_d[i] = (root_ok && root_idx == spmp_pkg::NodeBits'(i)) ? '0 : spmp_pkg::DistInf;
          done_d[i] = 1'b0;
          par_d[i]  = '0;
        end
        idx_d   = '0;
        found_d = 1'b0;
      end
      spmp_pkg::ST_SCAN: begin
        // Strict less-than keeps the lowest index on a tie.
        if (!done_q[idx_q] && (!found_q || alu_res.lt)) begin
          found_d = 1'b1;
          pick_d  = idx_q;
          best_d  = dist_q[idx_q];
        end
        idx_d = (idx_q == last_idx) ? '0 : idx_q + spmp_pkg::NodeBits'(1);
      end
      spmp_pkg::ST_MARK: begin
        if (found_q) begin
          done_d[pick_q] = 1'b1;
        end
        idx_d = '0;
      end
      spmp_pkg::ST_RELAX: begin
        mem_re   = 1'b1;
        rd_vld_d = 1'b1;
        idx_d    = (idx_q == last_idx) ? '0 : idx_q + spmp_pkg::NodeBits'(1);
      end
      spmp_pkg::ST_SETTLE: begin
        found_d = 1'b0;
        idx_d   = '0;
      end
      spmp_pkg::ST_EMIT: begin
        idx_d = (idx_q == last_idx) ? '0 : idx_q + spmp_pkg::NodeBits'(1);
      end
      default: ;
    endcase

    // Relaxation of the edge whose metric arrived from memory this cycle.
    if (rd_vld_q && !done_q[rd_idx_q] && rd_data_q[spmp_pkg::MetricBits] && !alu_res.sat) begin
      if (alu_res.eq) begin
        par_d[rd_idx_q] = par_q[rd_idx_q] | pick_bit;
      end else if (alu_res.lt) begin
        dist_d[rd_idx_q] = alu_res.sum;
        par_d[rd_idx_q]  = pick_bit;
      end
    end
  end

  always_comb begin
    res_o.valid     = state_q == spmp_pkg::ST_EMIT;
    res_o.node      = idx_q;
    res_o.path_dist = dist_q[idx_q];
    res_o.parents   = par_q[idx_q];
    res_o.last      = idx_q == last_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= spmp_pkg::ST_CLEAR;
      idx_q      <= '0;
      clr_addr_q <= '0;
      n_q        <= spmp_pkg::CountBits'(1);
      found_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      clr_addr_q <= clr_addr_d;
      n_q        <= n_d;
      found_q    <= found_d;
      rd_vld_q   <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q   <= pick_d;
    best_q   <= best_d;
    rd_idx_q <= rd_idx_d;
    dist_q   <= dist_d;
    done_q   <= done_d;
    par_q    <= par_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      edge_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= edge_mem[mem_raddr];
    end
  end

endmodule

### rtl/shortest_path_multi_parent.sv
// Top level of the shortest path block with equal-cost parent sets.
// Holds the configuration registers and the result register; depends on spmp_pkg
// and instantiates spmp_core.
`timescale 1ns / 1ps

// Channel        Direction  Handshake                      Payload
// command        in         start high while busy low      cmd_i, edge_source_i, edge_dest_i,
//                                                          edge_metric_i
// configuration  in         cfg_we_i high                  cfg_idx_i, cfg_data_i
// result         out        valid_o high for one cycle     node_index_o, path_distance_o,
//                                                          reached_o, parent_mask_o, last_o
//
// An add-edge transaction leaves the core idle, so the block is ready again at once.
// A clear transaction sweeps the edge memory one entry a cycle over all 1024 entries, and reset
// starts the same sweep, so busy stays high after reset until the sweep is done.
// A run transaction first sets up the node tables, then takes one round for each node picked
// at a finite distance, at most n rounds (a minimum scan over n nodes, a mark step, n edge
// reads and a settle step), then a closing scan and mark, then the n results, and busy
// falls when the output register empties; the single edge memory read port and the shared
// add and compare unit make the scan and the edge reads go one node at a time.
// The receiver cannot stall: each result is valid for exactly one cycle.

module shortest_path_multi_parent (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Command transaction.
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             cmd_i,
  input  logic [spmp_pkg::PortNodeBits-1:0]      edge_source_i,
  input  logic [spmp_pkg::PortNodeBits-1:0]      edge_dest_i,
  input  logic [spmp_pkg::MetricFieldBits-1:0]   edge_metric_i,
  // Configuration writes.
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_idx_i,
  input  logic [spmp_pkg::CountFieldBits-1:0]    cfg_data_i,
  // Result transaction.
  output logic                                   valid_o,
  output logic [spmp_pkg::PortNodeBits-1:0]      node_index_o,
  output logic [spmp_pkg::DistBits-1:0]          path_distance_o,
  output logic                                   reached_o,
  output logic [spmp_pkg::PortMaskBits-1:0]      parent_mask_o,
  output logic                                   last_o
);

  // Configuration registers: the root node and the number of nodes in use.
  logic [spmp_pkg::PortNodeBits-1:0]   root_q, root_d;
  logic [spmp_pkg::CountFieldBits-1:0] count_q, count_d;

  // Result register between the core and the ports.
  logic                                valid_q, valid_d;
  logic [spmp_pkg::PortNodeBits-1:0]   node_q, node_d;
  logic [spmp_pkg::DistBits-1:0]       dist_q, dist_d;
  logic                                reached_q, reached_d;
  logic [spmp_pkg::PortMaskBits-1:0]   mask_q, mask_d;
  logic                                last_q, last_d;

  logic [spmp_pkg::CountBits-1:0]      nodes_in_use;
  spmp_pkg::cmd_t                      core_cmd;
  spmp_pkg::res_t                      core_res;
  logic                                core_busy;

  always_comb begin
    root_d  = root_q;
    count_d = count_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        spmp_pkg::CFG_ROOT:  root_d  = cfg_data_i[spmp_pkg::PortNodeBits-1:0];
        spmp_pkg::CFG_COUNT: count_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // A count of zero means one node; a count above the node table saturates.
  always_comb begin
    if (count_q == '0) begin
      nodes_in_use = spmp_pkg::CountBits'(1);
    end else if (32'(count_q) > spmp_pkg::NodeLim) begin
      nodes_in_use = spmp_pkg::CountBits'(spmp_pkg::NodeLim);
    end else begin
      nodes_in_use = spmp_pkg::CountBits'(count_q);
    end
  end

  // Edges with an endpoint outside the node table are dropped here. The core takes no
  // command while the final result of a run still sits in the output register, so that
  // it accepts exactly when the port shows the handshake.
  always_comb begin
    core_cmd.start   = start && !valid_q;
    core_cmd.cmd     = cmd_i;
    core_cmd.src     = spmp_pkg::NodeBits'(edge_source_i);
    core_cmd.dst     = spmp_pkg::NodeBits'(edge_dest_i);
    core_cmd.ends_ok = (32'(edge_source_i) < spmp_pkg::MaxNodes) &&
                       (32'(edge_dest_i) < spmp_pkg::MaxNodes);
    core_cmd.metric  = spmp_pkg::sat_metric(edge_metric_i);
    core_cmd.root    = root_q;
    core_cmd.count   = nodes_in_use;
  end

  spmp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (core_cmd),
    .busy_o (core_busy),
    .res_o  (core_res)
  );

  // Unreached nodes report no parents, whatever the table holds.
  always_comb begin
    valid_d   = core_res.valid;
    node_d    = spmp_pkg::PortNodeBits'(core_res.node);
    dist_d    = core_res.path_dist;
    reached_d = core_res.path_dist != spmp_pkg::DistInf;
    mask_d    = reached_d ? spmp_pkg::PortMaskBits'(core_res.parents) : '0;
    last_d    = core_res.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= '0;
      count_q <= spmp_pkg::CountReset;
      valid_q <= 1'b0;
    end else begin
      root_q  <= root_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    dist_q    <= dist_d;
    reached_q <= reached_d;
    mask_q    <= mask_d;
    last_q    <= last_d;
  end

  // The final result still sits in the output register after the core goes idle,
  // so busy covers it too.
  assign busy            = core_busy | valid_q;
  assign valid_o         = valid_q;
  assign node_index_o    = node_q;
  assign path_distance_o = dist_q;
  assign reached_o       = reached_q;
  assign parent_mask_o   = mask_q;
  assign last_o          = last_q;

endmodule

### rtl/spmp_checker.sv
// Port-level checks on the shortest path block and the bind that attaches them.
// Depends on spmp_pkg and on the ports of shortest_path_multi_parent.
`timescale 1ns / 1ps

module spmp_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic [1:0]                           cmd_i,
  input logic                                 valid_o,
  input logic [spmp_pkg::PortNodeBits-1:0]    node_index_o,
  input logic [spmp_pkg::DistBits-1:0]        path_distance_o,
  input logic                                 reached_o,
  input logic [spmp_pkg::PortMaskBits-1:0]    parent_mask_o,
  input logic                                 last_o
);

  // A result never appears while the block claims to be ready.
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result shown while not busy");

  // Results of one run come back to back in ascending node order.
  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o &&
      node_index_o == $past(node_index_o) + spmp_pkg::PortNodeBits'(1))
    else $error("result sequence broken");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("result after the last one");

  // An edge write completes in the cycle it is taken.
  a_add_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i == spmp_pkg::CMD_ADD |=> !busy)
    else $error("add edge left the block busy");

  a_unreached_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (reached_o == (path_distance_o != spmp_pkg::DistInf)) &&
      (reached_o || parent_mask_o == '0))
    else $error("unreached node reported with distance or parents");

endmodule

bind shortest_path_multi_parent spmp_checker u_spmp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .cmd_i           (cmd_i),
  .valid_o         (valid_o),
  .node_index_o    (node_index_o),
  .path_distance_o (path_distance_o),
  .reached_o       (reached_o),
  .parent_mask_o   (parent_mask_o),
  .last_o          (last_o)
);
